// ===== src/sitd_pkg.sv =====
package sitd_pkg;

   // Field widths
   localparam int DATA_W      = 32;
   localparam int CHAR_W      = 7;
   localparam int NUM_DIGITS  = 10;
   localparam int BCD_W       = 4 * NUM_DIGITS;
   localparam int BIT_CNT_W   = $clog2(DATA_W);
   localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);

   // Character codes
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

   // Controller states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CONV = 5'b00010,
      ST_SIGN = 5'b00100,
      ST_SKIP = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;        // capture magnitude and sign, clear BCD
      logic conv_step;   // one double-dabble step
      logic digit_shift; // drop the top BCD digit
      logic sel_sign;    // present the minus sign
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic negative;
      logic top_zero;
   } status_type;

endpackage

// ===== src/sitd_if.sv =====
interface sitd_req_if
   import sitd_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface sitd_rsp_if
   import sitd_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ===== src/sitd_datapath.sv =====
module sitd_datapath
   import sitd_pkg::*;
(
   input  logic                     clock,
   input  logic signed [DATA_W-1:0] number,
   input  cmd_type                  cmd,
   output status_type               status,
   output logic [CHAR_W-1:0]        char_code
);

   logic [DATA_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;
   logic              neg_ff, neg_in;
   logic [BCD_W-1:0]  bcd_adj;
   logic [DATA_W-1:0] raw;

   assign raw = number;

   // Add-3 correction on every digit of 5 or more
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ?
                             bcd_ff[4*i +: 4] + 4'd3 : bcd_ff[4*i +: 4];
      end
   end

   // Next-state of the conversion registers
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      neg_in = neg_ff;
      if (cmd.load) begin
         neg_in = raw[DATA_W-1];
         bin_in = raw[DATA_W-1] ? (~raw + 1'b1) : raw;
         bcd_in = '0;
      end else if (cmd.conv_step) begin
         {bcd_in, bin_in} = {bcd_adj[BCD_W-2:0], bin_ff, 1'b0};
      end else if (cmd.digit_shift) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'b0000};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
   end

   assign status.negative = neg_ff;
   assign status.top_zero = (bcd_ff[BCD_W-1 -: 4] == 4'd0);

   // Character on the output beat
   assign char_code = cmd.sel_sign ? ASCII_MINUS
                                   : ASCII_ZERO + {3'b000, bcd_ff[BCD_W-1 -: 4]};

endmodule

// ===== src/sitd_ctrl.sv =====
module sitd_ctrl
   import sitd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_last,
   input  status_type status,
   output cmd_type    cmd
);

   state_type              state_ff, state_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIGIT_CNT_W-1:0] digit_cnt_ff, digit_cnt_in;

   localparam logic [BIT_CNT_W-1:0]   BIT_LAST   = BIT_CNT_W'(DATA_W - 1);
   localparam logic [DIGIT_CNT_W-1:0] DIGIT_FULL = DIGIT_CNT_W'(NUM_DIGITS);
   localparam logic [DIGIT_CNT_W-1:0] DIGIT_ONE  = DIGIT_CNT_W'(1);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_SIGN) || (state_ff == ST_EMIT);
   assign rsp_last  = (state_ff == ST_EMIT) && (digit_cnt_ff == DIGIT_ONE);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      digit_cnt_in = digit_cnt_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load     = 1'b1;
               bit_cnt_in   = BIT_LAST;
               digit_cnt_in = DIGIT_FULL;
               state_in     = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            bit_cnt_in    = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               state_in = status.negative ? ST_SIGN : ST_SKIP;
            end
         end
         ST_SIGN: begin
            cmd.sel_sign = 1'b1;
            if (rsp_ready) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // Leading zeros drop one per cycle; the units digit always stays
            if (status.top_zero && (digit_cnt_ff != DIGIT_ONE)) begin
               cmd.digit_shift = 1'b1;
               digit_cnt_in    = digit_cnt_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (digit_cnt_ff == DIGIT_ONE) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.digit_shift = 1'b1;
                  digit_cnt_in    = digit_cnt_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         digit_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         digit_cnt_ff <= digit_cnt_in;
      end
   end

   // An accepted number always starts conversion next cycle
   a_accept_to_conv: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_CONV))
      else $error("accepted beat did not start conversion");

   // The final beat of a number returns the block to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> (state_ff == ST_IDLE))
      else $error("block not idle after last beat");

   // Digit count stays in range while digits are pending
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SKIP) || (state_ff == ST_EMIT)) |->
      ((digit_cnt_ff != '0) && (digit_cnt_ff <= DIGIT_FULL)))
      else $error("digit count out of range");

   // A sign beat is offered only for negative numbers
   a_sign_neg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIGN) |-> status.negative)
      else $error("sign beat for non-negative number");

endmodule

// ===== src/signed_int_to_decimal_text.sv =====
// Signed 32-bit integer to decimal ASCII text.
// req_chan carries one signed number per beat; rsp_chan returns its text one
// character per beat, most significant first: '-' for negative values, then
// the digits without leading zeros ("0" for zero). is_last marks the final
// digit of each number.
// One number is in flight at a time: req_chan.ready is high only when idle.
// After acceptance the 32-bit magnitude runs through a double-dabble unit,
// one bit per cycle. Leading zero digits are then dropped one per cycle
// (up to 9), and each character takes one beat once rsp_chan.ready is
// high. Each stalled cycle on rsp_chan delays the return to idle and so
// the next accept.
// A stalled receiver simply holds the current character; nothing is lost.
// Reset (synchronous, active high) returns the controller to idle and drops
// any partly sent number.
module signed_int_to_decimal_text
   import sitd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sitd_req_if.sink   req_chan,
   sitd_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;

   sitd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_last  (rsp_chan.is_last),
      .status    (status),
      .cmd       (cmd)
   );

   sitd_datapath u_datapath (
      .clock     (clock),
      .number    (req_chan.number),
      .cmd       (cmd),
      .status    (status),
      .char_code (rsp_chan.char_code)
   );

endmodule
